[sv/grp_pkg.sv]
// Shared types for the guillotine rectangle packer.
// Item structs, CSR indexes and sequencer states. No dependencies.
package grp_pkg;

   typedef struct packed {
      logic        start_layout;
      logic [11:0] block_width;
      logic [11:0] block_height;
      logic [15:0] block_id;
   } req_type;

   typedef struct packed {
      logic        placed;
      logic [11:0] pos_x;
      logic [11:0] pos_y;
      logic [15:0] id_out;
   } rsp_type;

   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_BIN_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BIN_HEIGHT = 2'd1;
   localparam logic [11:0] BIN_RESET = 12'd1024;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_READ   = 5'b00010,
      ST_CHECK  = 5'b00100,
      ST_WRITE2 = 5'b01000,
      ST_OUT    = 5'b10000
   } state_type;

endpackage

[sv/guillotine_rect_packer_top.sv]
// Guillotine rectangle packer top level.
// Free list kept as a linked list in one synchronous memory; uses grp_pkg.
//
// Usage:
//  - req_* channel: one item per rectangle (valid/stall). start_layout=1 resets
//    the free list to the whole bin before the item is placed.
//  - rsp_* channel: exactly one result item per request, in order (valid/stall).
//  - csr_* channel: index 0 = bin_width, 1 = bin_height (valid/ready, always
//    ready). Write only while idle.
//  - Each free-list entry walked takes a memory read (ST_READ), then a compare
//    and modify (ST_CHECK); the walk ends at the first hit, or after all
//    entries when nothing fits. A hit is compared and then written back
//    (ST_CHECK, then ST_WRITE2) before ST_OUT loads the result register.
//  - One item in flight; a new item is accepted once the previous result
//    sits in the output register, even if the receiver stalls it.
//  - Reset: list empty (every item not placed until a layout start), bin
//    registers 1024 x 1024, output invalid. No clearing pass.
//  - rsp_stall holds the result register; the sequencer waits in its
//    output state until the register frees up.
module guillotine_rect_packer_top #(
   parameter int MAX_BLOCKS = 64,
   parameter int COORD_BITS = 12
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  grp_pkg::req_type                req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output grp_pkg::rsp_type                rsp_data,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [grp_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [11:0]                     csr_wdata
);
   import grp_pkg::*;

   localparam int CB      = COORD_BITS;
   localparam int DEPTH   = MAX_BLOCKS + 1;
   localparam int IDX_W   = $clog2(DEPTH);
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int ENTRY_W = 4 * CB + IDX_W;

   logic [ENTRY_W-1:0] mem [DEPTH];
   logic [ENTRY_W-1:0] rd_ff;
   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   logic [ENTRY_W-1:0] wr_data;
   logic               rd_en;

   state_type          state_ff, state_in;
   req_type            item_ff;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   steps_ff, steps_in;
   logic [IDX_W-1:0]   ptr_ff, ptr_in;
   logic [ENTRY_W-1:0] down_ff, down_in;
   logic               found_ff, found_in;
   logic [CB-1:0]      px_ff, px_in, py_ff, py_in;
   logic [11:0]        bin_w_ff, bin_h_ff;
   logic               rsp_valid_ff;
   rsp_type            rsp_ff;

   logic [CB-1:0]      w_c, h_c, ex, ey, ew, eh;
   logic [IDX_W-1:0]   enext;
   logic               accept, fits;

   assign w_c   = CB'(item_ff.block_width);
   assign h_c   = CB'(item_ff.block_height);
   assign ex    = rd_ff[4*CB+IDX_W-1 -: CB];
   assign ey    = rd_ff[3*CB+IDX_W-1 -: CB];
   assign ew    = rd_ff[2*CB+IDX_W-1 -: CB];
   assign eh    = rd_ff[CB+IDX_W-1 -: CB];
   assign enext = rd_ff[IDX_W-1:0];
   assign fits  = (w_c <= ew) && (h_c <= eh);

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      steps_in = steps_ff;
      ptr_in   = ptr_ff;
      down_in  = down_ff;
      found_in = found_ff;
      px_in    = px_ff;
      py_in    = py_ff;
      wr_en    = 1'b0;
      wr_addr  = '0;
      wr_data  = '0;
      rd_en    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               found_in = 1'b0;
               px_in    = '0;
               py_in    = '0;
               ptr_in   = '0;
               steps_in = '0;
               state_in = ST_READ;
               if (req_data.start_layout) begin
                  wr_en    = 1'b1;
                  wr_addr  = '0;
                  wr_data  = {CB'(0), CB'(0), CB'(bin_w_ff), CB'(bin_h_ff), IDX_W'(0)};
                  count_in = CNT_W'(1);
               end
            end
         end
         ST_READ: begin
            if (count_ff >= CNT_W'(DEPTH) || steps_ff == count_ff) begin
               state_in = ST_OUT;
            end else begin
               rd_en    = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (fits) begin
               wr_en    = 1'b1;
               wr_addr  = ptr_ff;
               wr_data  = {CB'(ex + w_c), ey, CB'(ew - w_c), h_c, count_ff[IDX_W-1:0]};
               down_in  = {ex, CB'(ey + h_c), ew, CB'(eh - h_c), enext};
               found_in = 1'b1;
               px_in    = ex;
               py_in    = ey;
               state_in = ST_WRITE2;
            end else begin
               ptr_in   = enext;
               steps_in = steps_ff + CNT_W'(1);
               state_in = ST_READ;
            end
         end
         ST_WRITE2: begin
            wr_en    = 1'b1;
            wr_addr  = count_ff[IDX_W-1:0];
            wr_data  = down_ff;
            count_in = count_ff + CNT_W'(1);
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_ff <= mem[ptr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         bin_w_ff     <= BIN_RESET;
         bin_h_ff     <= BIN_RESET;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_BIN_WIDTH:  bin_w_ff <= csr_wdata;
               CSR_BIN_HEIGHT: bin_h_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (state_ff == ST_OUT && (!rsp_valid_ff || !rsp_stall)) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      steps_ff <= steps_in;
      ptr_ff   <= ptr_in;
      down_ff  <= down_in;
      found_ff <= found_in;
      px_ff    <= px_in;
      py_ff    <= py_in;
      if (accept) begin
         item_ff <= req_data;
      end
      if (state_ff == ST_OUT && (!rsp_valid_ff || !rsp_stall)) begin
         rsp_ff.placed <= found_ff;
         rsp_ff.pos_x  <= 12'(px_ff);
         rsp_ff.pos_y  <= 12'(py_ff);
         rsp_ff.id_out <= item_ff.block_id;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("free list count out of range");

   a_count_grow: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_WRITE2 |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("free list did not grow after split");

   a_rsp_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_OUT))
      else $error("result raised outside output state");
`endif

endmodule
